@@ sv/fra_pkg.sv @@
package fra_pkg;

  // field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned FENCE_W = 64;

  // default table depth
  localparam int unsigned SLOTS_DEF = 16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUBMIT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

endpackage

@@ sv/fence_retired_slot_allocator_top.sv @@
// a request is taken only in idle; in_stall_o stays high through the table scan,
//   the finishing step and the return to idle, so no new request is taken before
//   the current one is through; the scan walks the slots through the single read port
//   of the slot memory, one slot per cycle, starting at the round-robin pointer
// a finished result waits in the output register while the next request is taken
// reset: asynchronous, empties the table at once (occupied flags in flops) and
//   sets the round-robin pointer to slot 0; no clearing pass
module fence_retired_slot_allocator_top
  import fra_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [ID_W-1:0]    work_id_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [FENCE_W-1:0] fence_value_i,
  input  logic [FENCE_W-1:0] completed_fence_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic [SLOT_W-1:0]  slot_out_o,
  output logic               all_retired_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned IW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam int unsigned MW = ID_W + FENCE_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  // latched request
  logic [KIND_W-1:0]  kind_q;
  logic [ID_W-1:0]    id_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FENCE_W-1:0] fence_q;
  logic [FENCE_W-1:0] done_q;

  // table state outside the memory
  logic [SLOTS-1:0] used_q;
  logic [AW-1:0]    next_q;

  // scan control
  logic [AW:0]   cnt_q;
  logic [AW-1:0] addr_q;
  logic          rv_q;
  logic [AW-1:0] ra_q;

  // scan accumulators
  logic          found_q;
  logic [AW-1:0] found_slot_q;
  logic          cand_q;
  logic [AW-1:0] cand_slot_q;
  logic          bad_all_q;
  logic          bad_oth_q;
  logic          lease_q;

  // output register
  logic              out_valid_q;
  logic              ok_q;
  logic [SLOT_W-1:0] slot_out_q;
  logic              ar_q;

  // memory ports
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [MW-1:0]   mem_wdata;
  logic            mem_re;
  logic [MW-1:0]   mem_rdata;
  logic [ID_W-1:0] rd_id;
  logic [FENCE_W-1:0] rd_fence;

  fra_ram #(
    .WIDTH(MW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(addr_q),
    .rdata_o(mem_rdata)
  );

  assign rd_id    = mem_rdata[MW-1:FENCE_W];
  assign rd_fence = mem_rdata[FENCE_W-1:0];

  logic accept;
  logic out_free;
  logic scan_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mem_re     = (state_q == ST_SCAN) && (cnt_q < (AW + 1)'(SLOTS));
  assign scan_done  = (cnt_q == (AW + 1)'(SLOTS)) && !rv_q;

  // per-slot checks on the returning read data
  logic used_r;
  logic retired_r;
  logic bad_r;
  logic id_hit_r;
  logic at_idx_r;

  assign used_r    = used_q[ra_q];
  assign retired_r = used_r && (rd_fence != '0) && (rd_fence <= done_q);
  assign bad_r     = used_r && !retired_r;
  assign id_hit_r  = used_r && (rd_id == id_q);
  assign at_idx_r  = (ra_q == AW'(slot_q));

  // result and update decision
  logic          id_nz;
  logic          idx_ok;
  logic          res_ok;
  logic [AW-1:0] res_where;
  logic          res_ar;

  assign id_nz  = (id_q != '0);
  assign idx_ok = (IW'(slot_q) < IW'(SLOTS));

  always_comb begin
    res_ok    = 1'b0;
    res_where = '0;
    res_ar    = !bad_all_q;
    unique case (kind_q)
      KIND_ACQUIRE: begin
        res_ok    = id_nz && !found_q && cand_q;
        res_where = res_ok ? cand_slot_q : '0;
        res_ar    = res_ok ? 1'b0 : !bad_all_q;
      end
      KIND_SUBMIT: begin
        res_ok = (fence_q != '0) && idx_ok && id_nz && lease_q;
        res_ar = res_ok ? (!bad_oth_q && (fence_q <= done_q)) : !bad_all_q;
      end
      KIND_RELEASE: begin
        res_ok = idx_ok && id_nz && lease_q;
        res_ar = res_ok ? !bad_oth_q : !bad_all_q;
      end
      KIND_FIND: begin
        res_ok    = id_nz && found_q;
        res_where = res_ok ? found_slot_q : '0;
      end
      KIND_CLEAR: begin
        res_ok = 1'b1;
        res_ar = 1'b1;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // memory write on the finishing cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(slot_q);
    mem_wdata = {id_q, fence_q};
    if ((state_q == ST_FINISH) && out_free && res_ok) begin
      if (kind_q == KIND_ACQUIRE) begin
        mem_we    = 1'b1;
        mem_waddr = cand_slot_q;
        mem_wdata = {id_q, {FENCE_W{1'b0}}};
      end else if (kind_q == KIND_SUBMIT) begin
        mem_we = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      id_q    <= work_id_i;
      slot_q  <= slot_i;
      fence_q <= fence_value_i;
      done_q  <= completed_fence_i;
    end
  end

  // read address walk, round-robin from the pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      addr_q <= '0;
      rv_q   <= 1'b0;
      ra_q   <= '0;
    end else begin
      rv_q <= mem_re;
      if (accept) begin
        cnt_q  <= '0;
        addr_q <= next_q;
      end else if (mem_re) begin
        cnt_q  <= cnt_q + 1'b1;
        ra_q   <= addr_q;
        addr_q <= (addr_q == AW'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
      end
    end
  end

  // scan accumulators
  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q      <= 1'b0;
      found_slot_q <= '0;
      cand_q       <= 1'b0;
      cand_slot_q  <= '0;
      bad_all_q    <= 1'b0;
      bad_oth_q    <= 1'b0;
      lease_q      <= 1'b0;
    end else if (rv_q) begin
      if (id_hit_r && !found_q) begin
        found_q      <= 1'b1;
        found_slot_q <= ra_q;
      end
      if (!bad_r && !cand_q) begin
        cand_q      <= 1'b1;
        cand_slot_q <= ra_q;
      end
      if (bad_r) begin
        bad_all_q <= 1'b1;
      end
      if (bad_r && !at_idx_r) begin
        bad_oth_q <= 1'b1;
      end
      if (at_idx_r && id_hit_r && (rd_fence == '0)) begin
        lease_q <= 1'b1;
      end
    end
  end

  // occupied flags and pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      next_q <= '0;
    end else if ((state_q == ST_FINISH) && out_free) begin
      if (kind_q == KIND_CLEAR) begin
        used_q <= '0;
        next_q <= '0;
      end else if (res_ok && (kind_q == KIND_ACQUIRE)) begin
        used_q[cand_slot_q] <= 1'b1;
        next_q <= (cand_slot_q == AW'(SLOTS - 1)) ? '0 : cand_slot_q + 1'b1;
      end else if (res_ok && (kind_q == KIND_RELEASE)) begin
        used_q[AW'(slot_q)] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FINISH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      ok_q       <= res_ok;
      slot_out_q <= SLOT_W'(res_where);
      ar_q       <= res_ar;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign slot_out_o    = slot_out_q;
  assign all_retired_o = ar_q;

endmodule

@@ sv/fra_ram.sv @@
module fra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
